// File: rtl/iirdf1_pkg.sv
package iirdf1_pkg;

    // coefficient format: signed Q2.16
    localparam int COEF_W = 18;
    localparam int FRAC_W = 16;
    // headroom for summing up to 256 taps
    localparam int GUARD_W = 8;

    // control of one history chain
    typedef struct packed {
        logic shift;   // new sample enters at the head, the oldest drops out
        logic rotate;  // every cell takes its successor, the head wraps to the tail
        logic flush;   // history cleared to zero (with shift: all but the new sample)
    } t_chain_ctl;

    // control of the shared multiply-accumulate
    typedef struct packed {
        logic clr;     // accumulator back to zero
        logic en;      // a tap is presented this cycle
        logic neg;     // feedback tap, subtract the product
    } t_mac_ctl;

    // feedforward coefficients b[k]
    function automatic logic signed [COEF_W-1:0] ff_coef(input logic [6:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            7'd0:  c = 18'sd140;    7'd1:  c = 18'sd235;    7'd2:  c = 18'sd380;
            7'd3:  c = 18'sd576;    7'd4:  c = 18'sd820;    7'd5:  c = 18'sd1109;
            7'd6:  c = 18'sd1440;   7'd7:  c = 18'sd1808;   7'd8:  c = 18'sd2208;
            7'd9:  c = 18'sd2633;   7'd10: c = 18'sd3076;   7'd11: c = 18'sd3529;
            7'd12: c = 18'sd3984;   7'd13: c = 18'sd4432;   7'd14: c = 18'sd4864;
            7'd15: c = 18'sd5272;   7'd16: c = 18'sd5648;   7'd17: c = 18'sd5983;
            7'd18: c = 18'sd6271;   7'd19: c = 18'sd6502;   7'd20: c = 18'sd6672;
            7'd21: c = 18'sd6774;   7'd22: c = 18'sd6804;   7'd23: c = 18'sd6759;
            7'd24: c = 18'sd6636;   7'd25: c = 18'sd6435;   7'd26: c = 18'sd6155;
            7'd27: c = 18'sd5798;   7'd28: c = 18'sd5367;   7'd29: c = 18'sd4865;
            7'd30: c = 18'sd4299;   7'd31: c = 18'sd3674;   7'd32: c = 18'sd2996;
            7'd33: c = 18'sd2275;   7'd34: c = 18'sd1517;   7'd35: c = 18'sd731;
            7'd36: c = -18'sd71;    7'd37: c = -18'sd881;   7'd38: c = -18'sd1687;
            7'd39: c = -18'sd2479;  7'd40: c = -18'sd3246;  7'd41: c = -18'sd3979;
            7'd42: c = -18'sd4667;  7'd43: c = -18'sd5302;  7'd44: c = -18'sd5876;
            7'd45: c = -18'sd6379;  7'd46: c = -18'sd6807;  7'd47: c = -18'sd7154;
            7'd48: c = -18'sd7414;
            default: c = '0;
        endcase
        return c;
    endfunction

    // feedback coefficients a[j+1]
    function automatic logic signed [COEF_W-1:0] fb_coef(input logic [5:0] idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            6'd0:  c = -18'sd62259; 6'd1:  c = 18'sd55706;  6'd2:  c = -18'sd49152;
            6'd3:  c = 18'sd42598;  6'd4:  c = -18'sd36045; 6'd5:  c = 18'sd29491;
            6'd6:  c = -18'sd22938; 6'd7:  c = 18'sd16384;  6'd8:  c = -18'sd9830;
            6'd9:  c = 18'sd3277;   6'd10: c = -18'sd1966;  6'd11: c = 18'sd655;
            6'd12: c = -18'sd524;   6'd13: c = 18'sd328;    6'd14: c = -18'sd197;
            6'd15: c = 18'sd66;     6'd16: c = -18'sd52;    6'd17: c = 18'sd33;
            6'd18: c = -18'sd20;    6'd19: c = 18'sd7;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/iirdf1_cell.sv
module iirdf1_cell #(
    parameter int W = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iirdf1_pkg::t_chain_ctl    i_ctl,
    input  logic [W-1:0]              i_prev,
    input  logic [W-1:0]              i_next,
    output logic [W-1:0]              o_val
);

    logic [W-1:0] r_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_ctl.shift) begin
            r_val <= i_prev;
        end else if (i_ctl.rotate) begin
            r_val <= i_next;
        end else if (i_ctl.flush) begin
            r_val <= '0;
        end
    end

    assign o_val = r_val;

endmodule

// File: rtl/iirdf1_chain.sv
module iirdf1_chain #(
    parameter int W     = 16,
    parameter int DEPTH = 49
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  iirdf1_pkg::t_chain_ctl    i_ctl,
    input  logic [W-1:0]              i_din,
    output logic [W-1:0]              o_head
);

    logic [W-1:0] val  [DEPTH];
    logic [W-1:0] prev [DEPTH];

    // cell 0 is the newest sample and the tap that the multiplier sees
    assign prev[0] = i_din;

    genvar g;
    generate
        for (g = 1; g < DEPTH; g++) begin : g_prev
            assign prev[g] = i_ctl.flush ? '0 : val[g-1];
        end
        for (g = 0; g < DEPTH; g++) begin : g_cell
            iirdf1_cell #(.W(W)) u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (i_ctl),
                .i_prev (prev[g]),
                .i_next (val[(g + 1) % DEPTH]),
                .o_val  (val[g])
            );
        end
    endgenerate

    assign o_head = val[0];

endmodule

// File: rtl/iirdf1_mac.sv
module iirdf1_mac #(
    parameter int SB = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  iirdf1_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [SB-1:0]                  i_sample,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]  i_coef,
    output logic signed [SB-1:0]                  o_y
);

    localparam int PROD_W = SB + iirdf1_pkg::COEF_W;
    localparam int ACC_W  = PROD_W + iirdf1_pkg::GUARD_W;
    localparam logic signed [ACC_W-1:0] HALF  = ACC_W'(1) <<< (iirdf1_pkg::FRAC_W - 1);
    localparam logic signed [ACC_W-1:0] Y_MAX = (ACC_W'(1) <<< (SB - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] Y_MIN = -Y_MAX - ACC_W'(1);

    logic signed [PROD_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_neg;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  y_wide;

    always_ff @(posedge i_clk) begin
        r_prod <= i_sample * i_coef;
        r_prod_neg <= i_ctl.neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_prod_vld <= i_ctl.en;
            if (i_ctl.clr) begin
                r_acc <= '0;
            end else if (r_prod_vld) begin
                r_acc <= r_prod_neg ? r_acc - ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
            end
        end
    end

    // round half up, then clamp
    assign rnd    = r_acc + HALF;
    assign y_wide = rnd >>> iirdf1_pkg::FRAC_W;

    always_comb begin
        if (y_wide > Y_MAX) begin
            o_y = SB'(Y_MAX);
        end else if (y_wide < Y_MIN) begin
            o_y = SB'(Y_MIN);
        end else begin
            o_y = SB'(y_wide);
        end
    end

endmodule

// File: rtl/iir_filter_direct_form_one_unit.sv
// timing: m_tvalid rises once the sequencer has passed through ST_RUN, ST_DRAIN and ST_DONE
//   after the edge that takes its item, later while the previous result is held
// flow: no new item is taken until the result reaches the output register, since the single
//   shared multiplier visits every tap in turn
// reset: synchronous, active low; both histories and all control clear at once
module iir_filter_direct_form_one_unit #(
    parameter int FEEDFORWARD_TAPS = 49,
    parameter int FEEDBACK_TAPS    = 20,
    parameter int SAMPLE_BITS      = 16,
    localparam int DATA_W          = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [DATA_W-1:0]        s_tdata,   // [SAMPLE_BITS-1:0] sample, rest zero padding
    input  logic                     s_tuser,   // [0] first
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [DATA_W-1:0]        m_tdata    // [SAMPLE_BITS-1:0] filtered, rest zero
);

    localparam int TAPS   = FEEDFORWARD_TAPS + FEEDBACK_TAPS;
    localparam int CNT_W  = $clog2(TAPS);

    // sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an item
    localparam logic [1:0] ST_RUN   = 2'd1;  // one tap per cycle through the multiplier
    localparam logic [1:0] ST_DRAIN = 2'd2;  // last product into the accumulator
    localparam logic [1:0] ST_DONE  = 2'd3;  // result to the output register

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic                   r_out_vld, n_out_vld;
    logic [SAMPLE_BITS-1:0] r_out, n_out;

    iirdf1_pkg::t_chain_ctl ff_ctl, fb_ctl;
    iirdf1_pkg::t_mac_ctl   mac_ctl;

    logic [SAMPLE_BITS-1:0]                   ff_head, fb_head;
    logic signed [SAMPLE_BITS-1:0]            y;
    logic signed [SAMPLE_BITS-1:0]            tap_sample;
    logic signed [iirdf1_pkg::COEF_W-1:0]     tap_coef;
    logic [CNT_W-1:0]                         fb_off;
    logic in_ff, last_tap, s_acc, out_free;

    assign s_tready = (r_state == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !r_out_vld || m_tready;

    // feedforward taps come first, then the feedback taps
    assign in_ff    = r_cnt < CNT_W'(FEEDFORWARD_TAPS);
    assign last_tap = r_cnt == CNT_W'(TAPS - 1);
    assign fb_off   = r_cnt - CNT_W'(FEEDFORWARD_TAPS);

    assign tap_sample = in_ff ? ff_head : fb_head;
    assign tap_coef   = in_ff ? iirdf1_pkg::ff_coef(7'(r_cnt))
                              : iirdf1_pkg::fb_coef(6'(fb_off));

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_out_vld = r_out_vld;
        n_out     = r_out;
        ff_ctl    = '0;
        fb_ctl    = '0;
        mac_ctl   = '0;

        if (r_out_vld && m_tready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    // new sample enters the input history, a first item wipes both
                    ff_ctl.shift = 1'b1;
                    ff_ctl.flush = s_tuser;
                    fb_ctl.flush = s_tuser;
                    mac_ctl.clr  = 1'b1;
                    n_cnt        = '0;
                    n_state      = ST_RUN;
                end
            end
            ST_RUN: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.neg = !in_ff;
                if (in_ff) begin
                    ff_ctl.rotate = 1'b1;
                end else begin
                    fb_ctl.rotate = 1'b1;
                end
                n_cnt = r_cnt + CNT_W'(1);
                if (last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // wait here while the previous result is still held
                if (out_free) begin
                    fb_ctl.shift = 1'b1;
                    n_out        = y;
                    n_out_vld    = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    // input history: x[n] down to x[n-FEEDFORWARD_TAPS+1]
    iirdf1_chain #(.W(SAMPLE_BITS), .DEPTH(FEEDFORWARD_TAPS)) u_ff_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (ff_ctl),
        .i_din  (s_tdata[SAMPLE_BITS-1:0]),
        .o_head (ff_head)
    );

    // output history: y[n-1] down to y[n-FEEDBACK_TAPS], saturated values
    iirdf1_chain #(.W(SAMPLE_BITS), .DEPTH(FEEDBACK_TAPS)) u_fb_chain (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (fb_ctl),
        .i_din  (y),
        .o_head (fb_head)
    );

    // shared multiplier and wide accumulator with rounding and saturation
    iirdf1_mac #(.SB(SAMPLE_BITS)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_sample(tap_sample),
        .i_coef  (tap_coef),
        .o_y     (y)
    );

    assign m_tvalid = r_out_vld;
    assign m_tdata  = DATA_W'(r_out);

endmodule
